@@ src/btghd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btghd_pkg: shared definitions for the button gesture detector
// Gesture codes, register indexes, widths and reset values.
// ----------------------------------------------------------------------------
package btghd_pkg;

  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int TAPS_W    = 2;

  typedef logic [1:0]           gesture_t;
  typedef logic [TIME_W-1:0]    time_t;
  typedef logic [CFG_W-1:0]     cfg_word_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [TAPS_W-1:0]    taps_t;

  // Gesture codes
  localparam gesture_t GESTURE_NONE   = 2'd0;
  localparam gesture_t GESTURE_HOLD   = 2'd1;
  localparam gesture_t GESTURE_DOUBLE = 2'd2;
  localparam gesture_t GESTURE_TRIPLE = 2'd3;

  // Register indexes
  localparam cfg_idx_t REG_HOLD_TIME  = 1'd0;
  localparam cfg_idx_t REG_TAP_WINDOW = 1'd1;

  // Register reset values
  localparam cfg_word_t HOLD_TIME_RST  = 16'd5000;
  localparam cfg_word_t TAP_WINDOW_RST = 16'd500;

  // Tap count limit
  localparam taps_t TAPS_MAX  = 2'd3;
  localparam taps_t TAPS_NONE = 2'd0;
  localparam taps_t TAPS_TWO  = 2'd2;

endpackage

@@ src/button_tap_hold_gesture_detector_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_tap_hold_gesture_detector_top: tap / hold gesture detector
// Takes one poll tick per word (timestamp, level, sample flag) and returns
// one gesture code per tick: none, hold, double tap or triple tap.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_stall  | in_now_ms[31:0], in_pressed, in_sample_valid
//  out     | out_valid/out_stall| out_gesture[1:0]
//  cfg     | cfg_valid/cfg_ready| cfg_index[0:0], cfg_data[15:0]
//
//  One word per cycle sustained unless the result is stalled; each word
//  passes the input register, then the result register. The gesture state is
//  updated as a word moves from the input register to the result register.
//  A stalled result holds both stages; in_stall rises only when both are full.
//  Reset (rst_n low, synchronous) empties both stages, clears the gesture
//  state and loads hold 5000 ms and tap window 500 ms. cfg_ready is always high.
// ----------------------------------------------------------------------------
module button_tap_hold_gesture_detector_top
  import btghd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  // input channel
  input  logic      in_valid,
  output logic      in_stall,
  input  time_t     in_now_ms,
  input  logic      in_pressed,
  input  logic      in_sample_valid,
  // result channel
  output logic      out_valid,
  input  logic      out_stall,
  output gesture_t  out_gesture,
  // configuration channel
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  cfg_idx_t  cfg_index,
  input  cfg_word_t cfg_data
);

  // Configuration registers
  cfg_word_t hold_time_r;
  cfg_word_t tap_window_r;

  // Input stage
  logic  s1_valid_r;
  time_t s1_now_r;
  logic  s1_lvl_r;
  logic  s1_ok_r;

  // Gesture state
  logic  prev_level_r, prev_level_nxt;
  time_t press_start_r, press_start_nxt;
  logic  hold_done_r, hold_done_nxt;
  taps_t taps_r, taps_nxt;
  time_t last_tap_r, last_tap_nxt;

  // Result stage
  logic     out_valid_r;
  gesture_t gesture_r, gesture_nxt;

  // Handshake
  logic s2_load;
  logic s1_load;

  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_gesture = gesture_r;
  assign s2_load     = !out_valid_r || !out_stall;
  assign in_stall    = s1_valid_r && !s2_load;
  assign s1_load     = in_valid && !in_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_time_r  <= HOLD_TIME_RST;
      tap_window_r <= TAP_WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HOLD_TIME:  hold_time_r  <= cfg_data;
        REG_TAP_WINDOW: tap_window_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (s2_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_now_r <= in_now_ms;
      s1_lvl_r <= in_pressed;
      s1_ok_r  <= in_sample_valid;
    end
  end

  // Per-tick gesture update
  always_comb begin
    logic  rise;
    logic  fall;
    logic  hd;
    time_t ps;
    time_t held;
    time_t quiet;
    taps_t tp;
    time_t lt;

    prev_level_nxt  = prev_level_r;
    press_start_nxt = press_start_r;
    hold_done_nxt   = hold_done_r;
    taps_nxt        = taps_r;
    last_tap_nxt    = last_tap_r;
    gesture_nxt     = GESTURE_NONE;

    rise  = s1_lvl_r && !prev_level_r;
    fall  = !s1_lvl_r && prev_level_r;
    ps    = rise ? s1_now_r : press_start_r;
    hd    = rise ? 1'b0 : hold_done_r;
    held  = s1_now_r - ps;
    tp    = taps_r;
    lt    = last_tap_r;

    // A release without a hold counts a tap (saturating)
    if (fall && !hd) begin
      tp = (taps_r == TAPS_MAX) ? TAPS_MAX : taps_r + taps_t'(1);
      lt = s1_now_r;
    end
    quiet = s1_now_r - lt;

    if (s1_ok_r) begin
      press_start_nxt = ps;
      if (s1_lvl_r && !hd && held >= time_t'(hold_time_r)) begin
        // hold fires once and cancels pending taps
        hold_done_nxt  = 1'b1;
        taps_nxt       = TAPS_NONE;
        prev_level_nxt = s1_lvl_r;
        gesture_nxt    = GESTURE_HOLD;
      end else begin
        hold_done_nxt  = fall ? 1'b0 : hd;
        prev_level_nxt = s1_lvl_r;
        last_tap_nxt   = lt;
        taps_nxt       = tp;
        // tap window closed: classify the tap count
        if (tp != TAPS_NONE && quiet >= time_t'(tap_window_r)) begin
          if (tp == TAPS_TWO) begin
            gesture_nxt = GESTURE_DOUBLE;
          end else if (tp == TAPS_MAX) begin
            gesture_nxt = GESTURE_TRIPLE;
          end
          taps_nxt = TAPS_NONE;
        end
      end
    end
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r  <= 1'b0;
      press_start_r <= '0;
      hold_done_r   <= 1'b0;
      taps_r        <= TAPS_NONE;
      last_tap_r    <= '0;
      out_valid_r   <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        prev_level_r  <= prev_level_nxt;
        press_start_r <= press_start_nxt;
        hold_done_r   <= hold_done_nxt;
        taps_r        <= taps_nxt;
        last_tap_r    <= last_tap_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid_r) begin
      gesture_r <= gesture_nxt;
    end
  end

endmodule

@@ src/btghd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btghd_checker: port-level checks for the gesture detector
// Watches the top-level ports only; attached by bind below.
// ----------------------------------------------------------------------------
module btghd_checker
  import btghd_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     in_sample_valid,
  input logic     out_valid,
  input logic     out_stall,
  input gesture_t out_gesture
);

  // Output stage is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_gesture))
    else $error("stalled result word changed");

  // Input backpressure only when the result side is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a stalled result");

  // A word with a bad sample comes out of the result register as no gesture
  a_bad_sample: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_sample_valid ##1 !out_stall
      |=> out_valid && out_gesture == GESTURE_NONE)
    else $error("bad sample produced a gesture");

endmodule

bind button_tap_hold_gesture_detector_top btghd_checker u_btghd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_sample_valid (in_sample_valid),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_gesture     (out_gesture)
);

@@ tb/tb_button_tap_hold_gesture_detector_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_tap_hold_gesture_detector_top: gesture detector testbench
// Sends poll-tick words and predicts the gesture code of each one with a
// local model of the detector. Results are checked in order. Coverage comes
// from directed taps, holds, wraps and register extremes, then from random
// tap bursts, long presses and noise under three back-pressure mixes.
// ----------------------------------------------------------------------------
module tb_button_tap_hold_gesture_detector_top;
  import btghd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic      clk             = 1'b0;
  logic      rst_n           = 1'b0;
  logic      in_valid        = 1'b0;
  logic      in_stall;
  time_t     in_now_ms       = '0;
  logic      in_pressed      = 1'b0;
  logic      in_sample_valid = 1'b0;
  logic      out_valid;
  logic      out_stall       = 1'b0;
  gesture_t  out_gesture;
  logic      cfg_valid       = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index       = REG_HOLD_TIME;
  cfg_word_t cfg_data        = '0;

  button_tap_hold_gesture_detector_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_now_ms       (in_now_ms),
    .in_pressed      (in_pressed),
    .in_sample_valid (in_sample_valid),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_gesture     (out_gesture),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // detector copy: configuration and gesture state
  cfg_word_t cfg_hold_ms     = HOLD_TIME_RST;
  cfg_word_t cfg_window_ms   = TAP_WINDOW_RST;
  logic      det_prev_level  = 1'b0;
  time_t     det_press_start = '0;
  logic      det_hold_done   = 1'b0;
  taps_t     det_taps        = TAPS_NONE;
  time_t     det_last_tap    = '0;

  gesture_t  expected_gestures[$];
  gesture_t  want_gesture;
  int        errors       = 0;
  int        cycle_count  = 0;
  int        ticks_sent   = 0;
  int        in_idle_pct  = 0;
  int        out_idle_pct = 0;
  time_t     stim_now     = '0;

  // gesture produced by one poll tick; updates the detector copy
  function automatic gesture_t predict_gesture(input time_t now, input logic lvl,
                                               input logic ok);
    gesture_t g;
    g = GESTURE_NONE;
    if (!ok) return GESTURE_NONE;
    // press edge starts a new press
    if (lvl && !det_prev_level) begin
      det_press_start = now;
      det_hold_done   = 1'b0;
    end
    // long press fires once and drops pending taps
    if (lvl && !det_hold_done &&
        time_t'(now - det_press_start) >= time_t'(cfg_hold_ms)) begin
      det_hold_done  = 1'b1;
      det_taps       = TAPS_NONE;
      det_prev_level = lvl;
      return GESTURE_HOLD;
    end
    // release: a tap unless the press already fired a hold
    if (!lvl && det_prev_level) begin
      if (!det_hold_done) begin
        if (det_taps != TAPS_MAX) det_taps = det_taps + 2'd1;
        det_last_tap = now;
      end
      det_hold_done = 1'b0;
    end
    det_prev_level = lvl;
    // quiet window over: classify the tap count
    if (det_taps != TAPS_NONE &&
        time_t'(now - det_last_tap) >= time_t'(cfg_window_ms)) begin
      if (det_taps == TAPS_TWO) g = GESTURE_DOUBLE;
      else if (det_taps == TAPS_MAX) g = GESTURE_TRIPLE;
      det_taps = TAPS_NONE;
    end
    return g;
  endfunction

  // send one word, wait for acceptance, queue its gesture
  task automatic send_tick(input time_t now, input logic lvl, input logic ok);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_now_ms       <= now;
    in_pressed      <= lvl;
    in_sample_valid <= ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_gestures.push_back(predict_gesture(now, lvl, ok));
    if (ok) ticks_sent++;
  endtask

  // advance the stimulus clock and send a valid sample; now and then a bad one first
  task automatic tick(input time_t step, input logic lvl);
    if ($urandom_range(9) == 0) send_tick($urandom, 1'($urandom_range(1)), 1'b0);
    stim_now = stim_now + step;
    send_tick(stim_now, lvl, 1'b1);
  endtask

  // drop valid, drain all results, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_gestures.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write both registers back to back once the block is idle
  task automatic set_config(input cfg_word_t hold_ms, input cfg_word_t window_ms);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_HOLD_TIME;
    cfg_data  <= hold_ms;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_hold_ms = hold_ms;
    cfg_index <= REG_TAP_WINDOW;
    cfg_data  <= window_ms;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_window_ms = window_ms;
    cfg_valid <= 1'b0;
  endtask

  // mostly modest values, with both extremes now and then
  function automatic cfg_word_t pick_cfg_value(input int typical_max);
    int r;
    r = $urandom_range(99);
    if (r < 12) return cfg_word_t'(1);
    if (r < 22) return cfg_word_t'(16'hFFFF);
    return cfg_word_t'($urandom_range(typical_max, 2));
  endfunction

  // burst of taps kept inside the window, then a quiet gap to classify
  task automatic play_taps(input int n_taps);
    int quick;
    int dn;
    quick = cfg_window_ms / 3;
    dn    = ((quick < cfg_hold_ms - 1) ? quick : cfg_hold_ms - 1) / 2;
    repeat (n_taps) begin
      // an occasional long gap splits the burst
      if ($urandom_range(7) == 0) tick(cfg_window_ms + $urandom_range(quick), 1'b1);
      else tick($urandom_range(quick), 1'b1);
      if ($urandom_range(3) == 0) tick($urandom_range(dn), 1'b1);
      tick($urandom_range(dn), 1'b0);
    end
    if ($urandom_range(1) == 0) tick($urandom_range(quick), 1'b0);
    tick(cfg_window_ms + $urandom_range(2), 1'b0);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_gestures.size() == 0) begin
        $display("%0t: unexpected gesture word %0d", $time, out_gesture);
        errors++;
      end else begin
        want_gesture = expected_gestures.pop_front();
        if (out_gesture !== want_gesture) begin
          $display("%0t: gesture mismatch, expected %0d, actual %0d",
                   $time, want_gesture, out_gesture);
          errors++;
        end
      end
    end
  end

  // random result back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // reset-value registers: taps, ignored sample, saturation, hold, wrap
  task automatic test_tap_gestures();
    send_tick(32'd0, 1'b0, 1'b1);
    send_tick(32'd10, 1'b1, 1'b1);
    send_tick(32'd20, 1'b0, 1'b1);
    send_tick(32'hFFFF_FFFF, 1'b1, 1'b0);     // bad sample leaves state alone
    send_tick(32'd40, 1'b1, 1'b1);
    send_tick(32'd50, 1'b0, 1'b1);
    send_tick(32'd550, 1'b0, 1'b1);           // window reached exactly: double
    // four taps saturate the count: triple
    for (int i = 0; i < 4; i++) begin
      send_tick(time_t'(1000 + 20 * i), 1'b1, 1'b1);
      send_tick(time_t'(1010 + 20 * i), 1'b0, 1'b1);
    end
    send_tick(32'd2000, 1'b0, 1'b1);
    // one short of the hold time, then exactly on it; release counts no tap
    send_tick(32'd3000, 1'b1, 1'b1);
    send_tick(32'd7999, 1'b1, 1'b1);
    send_tick(32'd8000, 1'b1, 1'b1);
    send_tick(32'd9000, 1'b0, 1'b1);
    // press before the clock wraps, hold fires after it
    send_tick(32'hFFFF_F000, 1'b1, 1'b1);
    send_tick(32'h0000_0400, 1'b1, 1'b1);
    send_tick(32'h0000_0500, 1'b0, 1'b1);
  endtask

  // zero and full-scale hold time and tap window
  task automatic test_register_extremes();
    set_config(16'd0, 16'd0);
    send_tick(32'd100, 1'b1, 1'b1);           // zero hold: fires on the press word
    send_tick(32'd100, 1'b0, 1'b1);
    set_config(16'hFFFF, 16'd0);
    send_tick(32'd200, 1'b1, 1'b1);
    send_tick(32'd201, 1'b0, 1'b1);           // zero window: classified on release
    set_config(16'hFFFF, 16'hFFFF);
    send_tick(32'd1000, 1'b1, 1'b1);
    send_tick(32'd66534, 1'b1, 1'b1);
    send_tick(32'd66535, 1'b1, 1'b1);
    send_tick(32'd70000, 1'b0, 1'b1);
    send_tick(32'd80000, 1'b1, 1'b1);
    send_tick(32'd80001, 1'b0, 1'b1);
    send_tick(32'd80002, 1'b1, 1'b1);
    send_tick(32'd80003, 1'b0, 1'b1);
    send_tick(32'd145537, 1'b0, 1'b1);
    send_tick(32'd145538, 1'b0, 1'b1);
  endtask

  // random gestures over several register settings
  task automatic test_random_gestures(input int n_ticks);
    int target;
    int pick;
    int quick;
    repeat (5) begin
      set_config(pick_cfg_value(300), pick_cfg_value(150));
      target = ticks_sent + n_ticks / 5;
      while (ticks_sent < target) begin
        pick  = $urandom_range(99);
        quick = cfg_window_ms / 3;
        // jump close to the wrap point
        if (pick < 15)
          stim_now = 32'hFFFF_FFFF - $urandom_range(cfg_hold_ms + cfg_window_ms);
        if (pick < 55) begin
          play_taps($urandom_range(5, 1));
        end else if (pick < 85) begin
          // long press: one short of hold, then on or past it, held, released
          tick($urandom_range(quick), 1'b1);
          tick(cfg_hold_ms - 1, 1'b1);
          tick($urandom_range(2, 1), 1'b1);
          tick($urandom_range(cfg_hold_ms), 1'b1);
          tick($urandom_range(quick), 1'b0);
        end else begin
          repeat ($urandom_range(3, 1))
            send_tick($urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    in_idle_pct  = 24;
    out_idle_pct = 55;
    test_tap_gestures();
    test_register_extremes();
    test_random_gestures(200);
    in_idle_pct  = 55;
    out_idle_pct = 24;
    test_random_gestures(200);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_gestures(200);
    wait_idle();
    if (errors == 0 && expected_gestures.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/btghd_pkg.sv
src/button_tap_hold_gesture_detector_top.sv
src/btghd_checker.sv
tb/tb_button_tap_hold_gesture_detector_top.sv
